>>> rtl/core/vfm_pkg.sv
// shared types, constants and corner table of the voxel face culling mesher
package vfm_pkg;

   // chunk geometry
   localparam int CHUNK_EDGE  = 16;
   localparam int VOXEL_COUNT = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;
   localparam int ADDR_W      = $clog2(VOXEL_COUNT);
   localparam int COORD_W     = 4;
   localparam int VERT_W      = 5;

   // operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_MESH  = 1'b1;

   // face codes, emitted in this order
   localparam logic [2:0] FACE_TOP    = 3'd0;
   localparam logic [2:0] FACE_BOTTOM = 3'd1;
   localparam logic [2:0] FACE_RIGHT  = 3'd2;
   localparam logic [2:0] FACE_LEFT   = 3'd3;
   localparam logic [2:0] FACE_BACK   = 3'd4;
   localparam logic [2:0] FACE_FRONT  = 3'd5;

   localparam logic [2:0] CORNER_LAST = 3'd5;

   typedef struct packed {
      logic               opcode;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic [7:0]         in_red;
      logic [7:0]         in_green;
      logic [7:0]         in_blue;
      logic [7:0]         in_alpha;
   } vfm_req_type;

   typedef struct packed {
      logic [VERT_W-1:0] vert_x;
      logic [VERT_W-1:0] vert_y;
      logic [VERT_W-1:0] vert_z;
      logic [7:0]        out_red;
      logic [7:0]        out_green;
      logic [7:0]        out_blue;
      logic [7:0]        out_alpha;
      logic [2:0]        face_id;
      logic              last_vertex;
   } vfm_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SELF,
      ST_PROBE,
      ST_EMIT
   } vfm_state_type;

   // corner offset {dx, dy, dz} of vertex k of a face
   function automatic logic [2:0] corner_of(input logic [2:0] face, input logic [2:0] k);
      logic [0:5][2:0] row;
      unique case (face)
         FACE_TOP:    row = {3'b010, 3'b011, 3'b111, 3'b010, 3'b111, 3'b110};
         FACE_BOTTOM: row = {3'b000, 3'b101, 3'b001, 3'b000, 3'b100, 3'b101};
         FACE_RIGHT:  row = {3'b100, 3'b110, 3'b111, 3'b100, 3'b111, 3'b101};
         FACE_LEFT:   row = {3'b000, 3'b011, 3'b010, 3'b000, 3'b001, 3'b011};
         FACE_BACK:   row = {3'b000, 3'b010, 3'b110, 3'b000, 3'b110, 3'b100};
         FACE_FRONT:  row = {3'b001, 3'b111, 3'b011, 3'b001, 3'b101, 3'b111};
         default:     row = '0;
      endcase
      return (k > CORNER_LAST) ? 3'b000 : row[k];
   endfunction

endpackage

>>> rtl/core/voxel_face_culling_mesher.sv
// voxel face culling mesher: voxel store, neighbour probe sequencer and vertex emitter
// sequence: a write completes in its accept cycle; a mesh item is accepted, reads its own voxel and,
//   if it is not empty, probes six neighbours, then emits six vertices per open face, held by rsp_stall
// throughput: one item at a time; the store read port and the vertex count set the rate
// reset: synchronous; afterwards a clearing pass zeroes the store one voxel a cycle,
//   with req_stall high throughout
module voxel_face_culling_mesher (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  vfm_pkg::vfm_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output vfm_pkg::vfm_rsp_type rsp_data
);
   import vfm_pkg::*;

   // voxel store, {alpha, blue, green, red}
   logic [31:0] mem [VOXEL_COUNT];

   vfm_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [COORD_W-1:0]   px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic [31:0]          voxel_ff, voxel_in;
   logic [2:0]           face_ff, face_in;
   logic [2:0]           corner_ff, corner_in;
   logic [5:0]           mask_ff, mask_in;
   logic [31:0]          rd_data_ff;

   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [31:0]          wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 req_in_range;
   logic                 probe_open;
   logic [5:0]           probe_mask;
   logic [3:0]           first_open, next_open;
   logic [2:0]           corner;

   // flat store address of a voxel
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                    input logic [COORD_W-1:0] y,
                                                    input logic [COORD_W-1:0] z);
      return ADDR_W'(x) * ADDR_W'(CHUNK_EDGE * CHUNK_EDGE) +
             ADDR_W'(y) * ADDR_W'(CHUNK_EDGE) + ADDR_W'(z);
   endfunction

   // store address of the neighbour across a face
   function automatic logic [ADDR_W-1:0] nbr_addr(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y,
                                                   input logic [COORD_W-1:0] z,
                                                   input logic [2:0] face);
      logic [ADDR_W-1:0] a;
      unique case (face)
         FACE_TOP:    a = cell_addr(x, y + 1'b1, z);
         FACE_BOTTOM: a = cell_addr(x, y - 1'b1, z);
         FACE_RIGHT:  a = cell_addr(x + 1'b1, y, z);
         FACE_LEFT:   a = cell_addr(x - 1'b1, y, z);
         FACE_BACK:   a = cell_addr(x, y, z - 1'b1);
         FACE_FRONT:  a = cell_addr(x, y, z + 1'b1);
         default:     a = cell_addr(x, y, z);
      endcase
      return a;
   endfunction

   // neighbour across the face lies outside the chunk
   function automatic logic nbr_outside(input logic [COORD_W-1:0] x,
                                        input logic [COORD_W-1:0] y,
                                        input logic [COORD_W-1:0] z,
                                        input logic [2:0] face);
      logic o;
      unique case (face)
         FACE_TOP:    o = (32'(y) == CHUNK_EDGE - 1);
         FACE_BOTTOM: o = (y == '0);
         FACE_RIGHT:  o = (32'(x) == CHUNK_EDGE - 1);
         FACE_LEFT:   o = (x == '0);
         FACE_BACK:   o = (z == '0);
         FACE_FRONT:  o = (32'(z) == CHUNK_EDGE - 1);
         default:     o = 1'b1;
      endcase
      return o;
   endfunction

   // first open face at or above start, {found, face}
   function automatic logic [3:0] find_open(input logic [5:0] mask, input logic [3:0] start);
      logic [3:0] r;
      r = '0;
      for (int i = 5; i >= 0; i--) begin
         if (mask[i] && (4'(i) >= start)) begin
            r = {1'b1, 3'(i)};
         end
      end
      return r;
   endfunction

   assign req_in_range = (32'(req_data.pos_x) < CHUNK_EDGE) &&
                         (32'(req_data.pos_y) < CHUNK_EDGE) &&
                         (32'(req_data.pos_z) < CHUNK_EDGE);

   // open test of the probed face
   assign probe_open = nbr_outside(px_ff, py_ff, pz_ff, face_ff) ||
                       (rd_data_ff[31:24] != voxel_ff[31:24]);
   assign probe_mask = mask_ff | (6'(probe_open) << face_ff);
   assign first_open = find_open(probe_mask, 4'd0);
   assign next_open  = find_open(mask_ff, {1'b0, face_ff} + 4'd1);

   // next state and sequencer registers
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      px_in     = px_ff;
      py_in     = py_ff;
      pz_in     = pz_ff;
      voxel_in  = voxel_ff;
      face_in   = face_ff;
      corner_in = corner_ff;
      mask_in   = mask_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (32'(clr_ff) == VOXEL_COUNT - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            px_in = req_data.pos_x;
            py_in = req_data.pos_y;
            pz_in = req_data.pos_z;
            if (req_valid && req_data.opcode == OP_MESH && req_in_range) begin
               state_in = ST_SELF;
            end
         end
         ST_SELF: begin
            voxel_in = rd_data_ff;
            face_in  = FACE_TOP;
            mask_in  = '0;
            state_in = (rd_data_ff[31:24] == 8'd0) ? ST_IDLE : ST_PROBE;
         end
         ST_PROBE: begin
            mask_in = probe_mask;
            if (face_ff == FACE_FRONT) begin
               face_in   = first_open[2:0];
               corner_in = '0;
               state_in  = first_open[3] ? ST_EMIT : ST_IDLE;
            end else begin
               face_in = face_ff + 1'b1;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall) begin
               if (corner_ff == CORNER_LAST) begin
                  corner_in = '0;
                  face_in   = next_open[2:0];
                  if (!next_open[3]) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  corner_in = corner_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake, store port control and vertex payload
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      wr_en     = 1'b0;
      wr_addr   = cell_addr(req_data.pos_x, req_data.pos_y, req_data.pos_z);
      wr_data   = {req_data.in_alpha, req_data.in_blue, req_data.in_green, req_data.in_red};
      rd_addr   = cell_addr(px_ff, py_ff, pz_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
         end
         ST_IDLE: begin
            wr_en   = req_valid && req_data.opcode == OP_WRITE && req_in_range;
            rd_addr = cell_addr(req_data.pos_x, req_data.pos_y, req_data.pos_z);
         end
         ST_SELF:  rd_addr = nbr_addr(px_ff, py_ff, pz_ff, FACE_TOP);
         ST_PROBE: rd_addr = nbr_addr(px_ff, py_ff, pz_ff, face_ff + 1'b1);
         ST_EMIT:  rd_addr = cell_addr(px_ff, py_ff, pz_ff);
         default:  rd_addr = cell_addr(px_ff, py_ff, pz_ff);
      endcase
      corner               = corner_of(face_ff, corner_ff);
      rsp_data.vert_x      = VERT_W'(px_ff) + VERT_W'(corner[2]);
      rsp_data.vert_y      = VERT_W'(py_ff) + VERT_W'(corner[1]);
      rsp_data.vert_z      = VERT_W'(pz_ff) + VERT_W'(corner[0]);
      rsp_data.out_red     = voxel_ff[7:0];
      rsp_data.out_green   = voxel_ff[15:8];
      rsp_data.out_blue    = voxel_ff[23:16];
      rsp_data.out_alpha   = voxel_ff[31:24];
      rsp_data.face_id     = face_ff;
      rsp_data.last_vertex = (corner_ff == CORNER_LAST) && !next_open[3];
   end

   // voxel store, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      px_ff     <= px_in;
      py_ff     <= py_in;
      pz_ff     <= pz_in;
      voxel_ff  <= voxel_in;
      face_ff   <= face_in;
      corner_ff <= corner_in;
      mask_ff   <= mask_in;
   end

`ifndef SYNTHESIS
   // only non-empty voxels produce vertices
   a_alpha_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.out_alpha != 8'd0)
      else $error("vertex emitted for empty voxel");

   // every emitted face was found open by the probe
   a_face_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> mask_ff[face_ff])
      else $error("vertex emitted for hidden face");

   // the last vertex taken ends the mesh transaction
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_data.last_vertex) |=> state_ff == ST_IDLE)
      else $error("sequencer kept running after last vertex");

   // the final probe always leads to emission or idle
   a_probe_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && face_ff == FACE_FRONT) |=>
         (state_ff == ST_EMIT || state_ff == ST_IDLE))
      else $error("bad exit from neighbour probe");
`endif

endmodule
